// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// condition holds in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/core/rv32ie_pkg.sv
`default_nettype none
package rv32ie_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [XLEN-1:0] SP_DEFAULT = 32'h0000_6d40;

    // configuration register indexes
    localparam logic [0:0] CFG_SP = 1'b0;
    localparam logic [0:0] CFG_PC = 1'b1;

    // opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    // funct7 groups
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // mul/div funct3
    localparam logic [2:0] MD_MUL    = 3'd0;
    localparam logic [2:0] MD_MULH   = 3'd1;
    localparam logic [2:0] MD_MULHSU = 3'd2;
    localparam logic [2:0] MD_MULHU  = 3'd3;
    localparam logic [2:0] MD_DIV    = 3'd4;
    localparam logic [2:0] MD_DIVU   = 3'd5;
    localparam logic [2:0] MD_REM    = 3'd6;
    localparam logic [2:0] MD_REMU   = 3'd7;

    // load and store widths
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;
    localparam logic [2:0] ST_B  = 3'd0;
    localparam logic [2:0] ST_H  = 3'd1;
    localparam logic [2:0] ST_W  = 3'd2;

    // branch conditions
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    localparam logic [2:0]  F3_PRIV     = 3'd0;
    localparam logic [11:0] FN12_EBREAK = 12'd1;

    // result codes
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNDEF  = 2'd1;
    localparam logic [1:0] ST_EBREAK = 2'd2;
    localparam logic [1:0] ST_KIND   = 2'd3;

    // start request to the mul/div unit
    typedef struct packed {
        logic       start;
        logic [2:0] funct3;
    } t_md_req;

endpackage
`default_nettype wire

// File: rtl/core/rv32im_instruction_execute.sv
// channel  | dir | valid / ready                 | payload
// ---------+-----+-------------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata word, tuser req_type
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata result fields, tuser access_kind
// cfg      | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// load data request: OUT; instruction: READ, EXEC, OUT (register file read is registered)
// mul/div: READ, EXEC, MD, OUT; MD waits on the serial unit (one bit per cycle, 32 steps)
// synchronous active-low reset; register file valid bits clear at once, no clearing pass
// a result waits in the output register while the next request is taken

`default_nettype none
`include "assert_macros.svh"
module rv32im_instruction_execute import rv32ie_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // word
    input  wire logic [0:0]   s_axis_tuser,   // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // next_pc, access_addr, byte_enable, store_data, status, retired_count, pad
    output logic      [135:0] m_axis_tdata,
    output logic      [1:0]   m_axis_tuser,   // access_kind
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [REG_AW-1:0] REG_SP = REG_AW'(2);

    logic [2:0]          r_state;
    logic [XLEN-1:0]     r_pc;
    logic [XLEN-1:0]     r_sp;
    logic [XLEN-1:0]     r_cnt;
    logic                r_ld_pend;
    logic [REG_AW-1:0]   r_ld_dest;
    logic [2:0]          r_ld_f3;
    logic [1:0]          r_ld_off;
    logic [REG_COUNT-1:0] r_valid;
    logic [XLEN-1:0]     r_ins;
    logic [1:0]          r_p_kind;
    logic [XLEN-1:0]     r_p_addr;
    logic [3:0]          r_p_be;
    logic [XLEN-1:0]     r_p_sdata;
    logic [1:0]          r_p_status;
    logic                r_m_valid;
    logic [135:0]        r_m_tdata;
    logic [1:0]          r_m_tuser;

    logic                w_acc;
    logic                w_out_free;
    logic [6:0]          w_opc;
    logic [REG_AW-1:0]   w_rd;
    logic [REG_AW-1:0]   w_rs1;
    logic [REG_AW-1:0]   w_rs2;
    logic [2:0]          w_f3;
    logic [6:0]          w_f7;
    logic [XLEN-1:0]     w_ram_a;
    logic [XLEN-1:0]     w_ram_b;
    logic [XLEN-1:0]     w_a;
    logic [XLEN-1:0]     w_b;
    logic [XLEN-1:0]     w_immi;
    logic [XLEN-1:0]     w_imms;
    logic [XLEN-1:0]     w_immb;
    logic [XLEN-1:0]     w_immj;
    logic [XLEN-1:0]     w_immu;
    logic [XLEN-1:0]     w_op2;
    logic [4:0]          w_shamt;
    logic [XLEN-1:0]     w_alu;
    logic [XLEN-1:0]     w_ea_l;
    logic [XLEN-1:0]     w_ea_s;
    logic [XLEN-1:0]     w_ld_sh;
    logic [XLEN-1:0]     w_ld_hw;
    logic [XLEN-1:0]     w_ld_val;
    logic                w_take;
    logic                w_md_done;
    logic [XLEN-1:0]     w_md_res;
    t_md_req             w_md_req;
    logic                w_we;
    logic [REG_AW-1:0]   w_waddr;
    logic [XLEN-1:0]     w_wdata;

    logic [XLEN-1:0]     n_npc;
    logic [1:0]          n_kind;
    logic [XLEN-1:0]     n_addr;
    logic [3:0]          n_be;
    logic [XLEN-1:0]     n_sdata;
    logic [1:0]          n_status;
    logic                n_wb_en;
    logic [XLEN-1:0]     n_wb_data;
    logic                n_ld;
    logic                n_md;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // instruction fields
    assign w_opc  = r_ins[6:0];
    assign w_rd   = r_ins[11:7];
    assign w_f3   = r_ins[14:12];
    assign w_rs1  = r_ins[19:15];
    assign w_rs2  = r_ins[24:20];
    assign w_f7   = r_ins[31:25];
    assign w_immi = {{20{r_ins[31]}}, r_ins[31:20]};
    assign w_imms = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign w_immb = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign w_immj = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
    assign w_immu = {r_ins[31:12], 12'b0};

    // register file, unwritten entries read as zero, sp as the r_sp value
    rv32ie_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_rs1),
        .i_raddr_b (w_rs2),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    assign w_a = r_valid[w_rs1] ? w_ram_a : ((w_rs1 == REG_SP) ? r_sp : '0);
    assign w_b = r_valid[w_rs2] ? w_ram_b : ((w_rs2 == REG_SP) ? r_sp : '0);

    // alu
    assign w_op2   = (w_opc == OPC_OP) ? w_b : w_immi;
    assign w_shamt = w_op2[4:0];
    assign w_ea_l  = w_a + w_immi;
    assign w_ea_s  = w_a + w_imms;

    always_comb begin
        unique case (w_f3)
            F3_ADD:  w_alu = ((w_opc == OPC_OP) && r_ins[30]) ? (w_a - w_op2) : (w_a + w_op2);
            F3_SLL:  w_alu = w_a << w_shamt;
            F3_SLT:  w_alu = {31'b0, $signed(w_a) < $signed(w_op2)};
            F3_SLTU: w_alu = {31'b0, w_a < w_op2};
            F3_XOR:  w_alu = w_a ^ w_op2;
            F3_SRL:  w_alu = r_ins[30] ? $unsigned($signed(w_a) >>> w_shamt) : (w_a >> w_shamt);
            F3_OR:   w_alu = w_a | w_op2;
            F3_AND:  w_alu = w_a & w_op2;
            default: w_alu = '0;
        endcase
    end

    // branch condition
    always_comb begin
        unique case (w_f3)
            BR_EQ:   w_take = (w_a == w_b);
            BR_NE:   w_take = (w_a != w_b);
            BR_LT:   w_take = $signed(w_a) < $signed(w_b);
            BR_GE:   w_take = !($signed(w_a) < $signed(w_b));
            BR_LTU:  w_take = (w_a < w_b);
            BR_GEU:  w_take = (w_a >= w_b);
            default: w_take = 1'b0;
        endcase
    end

    // execute decode
    always_comb begin
        n_npc     = r_pc + 32'd4;
        n_kind    = ACC_NONE;
        n_addr    = '0;
        n_be      = '0;
        n_sdata   = '0;
        n_status  = ST_OK;
        n_wb_en   = 1'b0;
        n_wb_data = '0;
        n_ld      = 1'b0;
        n_md      = 1'b0;
        unique case (w_opc)
            OPC_OP: begin
                if (w_f7 == F7_MULDIV) begin
                    n_md = 1'b1;
                end else if ((w_f7 == F7_BASE) ||
                             ((w_f7 == F7_ALT) && ((w_f3 == F3_ADD) || (w_f3 == F3_SRL)))) begin
                    n_wb_en   = 1'b1;
                    n_wb_data = w_alu;
                end else begin
                    n_status = ST_UNDEF;
                end
            end
            OPC_OPIMM: begin
                n_wb_en   = 1'b1;
                n_wb_data = w_alu;
            end
            OPC_LOAD: begin
                if ((w_f3 == LD_B) || (w_f3 == LD_H) || (w_f3 == LD_W) ||
                    (w_f3 == LD_BU) || (w_f3 == LD_HU)) begin
                    if (w_rd != '0) begin
                        n_ld   = 1'b1;
                        n_kind = ACC_LOAD;
                        n_addr = (w_f3 == LD_W) ? w_ea_l : {w_ea_l[XLEN-1:2], 2'b00};
                    end
                end else begin
                    n_status = ST_UNDEF;
                end
            end
            OPC_STORE: begin
                unique case (w_f3)
                    ST_B: begin
                        n_kind  = ACC_STORE;
                        n_addr  = {w_ea_s[XLEN-1:2], 2'b00};
                        n_be    = 4'b0001 << w_ea_s[1:0];
                        n_sdata = {24'b0, w_b[7:0]} << {w_ea_s[1:0], 3'b000};
                    end
                    ST_H: begin
                        n_kind  = ACC_STORE;
                        n_addr  = {w_ea_s[XLEN-1:2], 2'b00};
                        n_be    = w_ea_s[1] ? 4'b1100 : 4'b0011;
                        n_sdata = w_ea_s[1] ? {w_b[15:0], 16'b0} : {16'b0, w_b[15:0]};
                    end
                    ST_W: begin
                        n_kind  = ACC_STORE;
                        n_addr  = w_ea_s;
                        n_be    = 4'b1111;
                        n_sdata = w_b;
                    end
                    default: n_status = ST_UNDEF;
                endcase
            end
            OPC_BRANCH: begin
                if ((w_f3 == 3'd2) || (w_f3 == 3'd3)) begin
                    n_status = ST_UNDEF;
                end else if (w_take) begin
                    n_npc = r_pc + w_immb;
                end
            end
            OPC_JAL: begin
                n_npc     = r_pc + w_immj;
                n_wb_en   = 1'b1;
                n_wb_data = r_pc + 32'd4;
            end
            OPC_JALR: begin
                if (w_f3 != F3_ADD) begin
                    n_status = ST_UNDEF;
                end else begin
                    n_npc     = {w_ea_l[XLEN-1:1], 1'b0};
                    n_wb_en   = 1'b1;
                    n_wb_data = r_pc + 32'd4;
                end
            end
            OPC_LUI: begin
                n_wb_en   = 1'b1;
                n_wb_data = w_immu;
            end
            OPC_AUIPC: begin
                n_wb_en   = 1'b1;
                n_wb_data = r_pc + w_immu;
            end
            OPC_SYSTEM: begin
                if ((w_f3 == F3_PRIV) && (r_ins[31:20] == FN12_EBREAK)) begin
                    n_status = ST_EBREAK;
                end else begin
                    n_status = ST_UNDEF;
                end
            end
            default: n_status = ST_UNDEF;
        endcase
    end

    // load data alignment and extension
    assign w_ld_sh = s_axis_tdata >> {r_ld_off, 3'b000};
    assign w_ld_hw = r_ld_off[1] ? {16'b0, s_axis_tdata[31:16]} : s_axis_tdata;

    always_comb begin
        unique case (r_ld_f3)
            LD_B:    w_ld_val = {{24{w_ld_sh[7]}}, w_ld_sh[7:0]};
            LD_H:    w_ld_val = {{16{w_ld_hw[15]}}, w_ld_hw[15:0]};
            LD_BU:   w_ld_val = {24'b0, w_ld_sh[7:0]};
            LD_HU:   w_ld_val = {16'b0, w_ld_hw[15:0]};
            default: w_ld_val = s_axis_tdata;
        endcase
    end

    // mul/div unit
    assign w_md_req.start  = (r_state == S_EXEC) && n_md;
    assign w_md_req.funct3 = w_f3;

    rv32ie_md u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_md_req),
        .i_op_a   (w_a),
        .i_op_b   (w_b),
        .o_done   (w_md_done),
        .o_result (w_md_res)
    );

    // register file write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_rd;
        w_wdata = n_wb_data;
        priority if (w_acc && s_axis_tuser[0] && r_ld_pend) begin
            w_we    = 1'b1;
            w_waddr = r_ld_dest;
            w_wdata = w_ld_val;
        end else if (r_state == S_EXEC) begin
            w_we = n_wb_en && (w_rd != '0);
        end else if ((r_state == S_MD) && w_md_done) begin
            w_we    = (w_rd != '0);
            w_wdata = w_md_res;
        end else begin
            w_we = 1'b0;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_sp      <= SP_DEFAULT;
            r_cnt     <= '0;
            r_ld_pend <= 1'b0;
            r_ld_dest <= '0;
            r_ld_f3   <= '0;
            r_ld_off  <= '0;
            r_valid   <= '0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SP) begin
                    r_sp            <= i_cfg_data;
                    r_valid[REG_SP] <= 1'b0;
                end else begin
                    r_pc <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (!s_axis_tuser[0] && !r_ld_pend) begin
                            r_cnt   <= r_cnt + 32'd1;
                            r_state <= S_READ;
                        end else begin
                            if (s_axis_tuser[0] && r_ld_pend) begin
                                r_ld_pend <= 1'b0;
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_pc <= n_npc;
                    if (n_ld) begin
                        r_ld_pend <= 1'b1;
                        r_ld_dest <= w_rd;
                        r_ld_f3   <= w_f3;
                        r_ld_off  <= w_ea_l[1:0];
                    end
                    r_state <= n_md ? S_MD : S_OUT;
                end
                S_MD: begin
                    if (w_md_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ins      <= s_axis_tdata;
            r_p_kind   <= ACC_NONE;
            r_p_addr   <= '0;
            r_p_be     <= '0;
            r_p_sdata  <= '0;
            r_p_status <= (s_axis_tuser[0] == r_ld_pend) ? ST_OK : ST_KIND;
        end else if (r_state == S_EXEC) begin
            r_p_kind   <= n_kind;
            r_p_addr   <= n_addr;
            r_p_be     <= n_be;
            r_p_sdata  <= n_sdata;
            r_p_status <= n_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_tdata <= {2'b00, r_cnt, r_p_status, r_p_sdata, r_p_be, r_p_addr, r_pc};
            r_m_tuser <= r_p_kind;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // checks
    `CHK_NEXT(a_ins_read, i_clk, i_rst_n, w_acc && !s_axis_tuser[0] && !r_ld_pend, r_state == S_READ)
    `CHK_SAME(a_md_done, i_clk, i_rst_n, w_md_done, r_state == S_MD)
    `CHK_SAME(a_ld_dest, i_clk, i_rst_n, r_ld_pend, r_ld_dest != '0)

endmodule
`default_nettype wire

// File: rtl/core/rv32ie_ram.sv
`default_nettype none
module rv32ie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// File: rtl/core/rv32ie_md.sv
`default_nettype none
module rv32ie_md import rv32ie_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_md_req         i_req,
    input  wire logic [XLEN-1:0] i_op_a,
    input  wire logic [XLEN-1:0] i_op_b,
    output logic                 o_done,
    output logic      [XLEN-1:0] o_result
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_LOOP = 3'd1;
    localparam logic [2:0] M_FIX1 = 3'd2;
    localparam logic [2:0] M_FIX2 = 3'd3;
    localparam logic [2:0] M_DONE = 3'd4;

    localparam int CW = $clog2(XLEN);

    logic [2:0]      r_state;
    logic [2:0]      r_f3;
    logic [CW-1:0]   r_cnt;
    logic [XLEN-1:0] r_a;
    logic [XLEN-1:0] r_b;
    logic [XLEN-1:0] r_hi;
    logic [XLEN-1:0] r_lo;
    logic            r_fix1;
    logic            r_fix2;

    logic            w_div;
    logic            w_sg;
    logic [XLEN-1:0] w_abs_a;
    logic [XLEN-1:0] w_abs_b;
    logic [XLEN:0]   w_sum;
    logic [XLEN+1:0] w_trial;

    // operand preparation
    assign w_div   = i_req.funct3[2];
    assign w_sg    = (i_req.funct3 == MD_DIV) || (i_req.funct3 == MD_REM);
    assign w_abs_a = (w_sg && i_op_a[XLEN-1]) ? ('0 - i_op_a) : i_op_a;
    assign w_abs_b = (w_sg && i_op_b[XLEN-1]) ? ('0 - i_op_b) : i_op_b;

    // one bit of shift-add product or of restoring quotient per cycle
    assign w_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : '0);
    assign w_trial = {1'b0, r_hi, r_lo[XLEN-1]} - {2'b00, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_state <= M_LOOP;
                    end
                end
                M_LOOP: begin
                    if (r_cnt == CW'(XLEN - 1)) begin
                        r_state <= M_FIX1;
                    end
                end
                M_FIX1:  r_state <= M_FIX2;
                M_FIX2:  r_state <= M_DONE;
                M_DONE:  r_state <= M_IDLE;
                default: r_state <= M_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                r_f3  <= i_req.funct3;
                r_cnt <= '0;
                r_hi  <= '0;
                r_a   <= i_op_a;
                if (w_div) begin
                    r_lo   <= w_abs_a;
                    r_b    <= w_abs_b;
                    r_fix1 <= w_sg && (i_op_a[XLEN-1] ^ i_op_b[XLEN-1]) && (i_op_b != '0);
                    r_fix2 <= w_sg && i_op_a[XLEN-1];
                end else begin
                    r_lo   <= i_op_a;
                    r_b    <= i_op_b;
                    r_fix1 <= ((i_req.funct3 == MD_MULH) || (i_req.funct3 == MD_MULHSU))
                              && i_op_a[XLEN-1];
                    r_fix2 <= (i_req.funct3 == MD_MULH) && i_op_b[XLEN-1];
                end
            end
            M_LOOP: begin
                r_cnt <= r_cnt + CW'(1);
                if (r_f3[2]) begin
                    if (!w_trial[XLEN+1]) begin
                        r_hi <= w_trial[XLEN-1:0];
                    end else begin
                        r_hi <= {r_hi[XLEN-2:0], r_lo[XLEN-1]};
                    end
                    r_lo <= {r_lo[XLEN-2:0], !w_trial[XLEN+1]};
                end else begin
                    r_hi <= w_sum[XLEN:1];
                    r_lo <= {w_sum[0], r_lo[XLEN-1:1]};
                end
            end
            // quotient sign, or signed correction for a negative a
            M_FIX1: begin
                if (r_fix1) begin
                    if (r_f3[2]) begin
                        r_lo <= '0 - r_lo;
                    end else begin
                        r_hi <= r_hi - r_b;
                    end
                end
            end
            // remainder sign, or signed correction for a negative b
            M_FIX2: begin
                if (r_fix2) begin
                    if (r_f3[2]) begin
                        r_hi <= '0 - r_hi;
                    end else begin
                        r_hi <= r_hi - r_a;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = (r_state == M_DONE);
    assign o_result = ((r_f3 == MD_MUL) || (r_f3 == MD_DIV) || (r_f3 == MD_DIVU)) ? r_lo : r_hi;

endmodule
`default_nettype wire
